// ----- rtl/hsa_pkg.sv -----
// ----------------------------------------------------------------------------
// hsa_pkg
// Types, constants and helpers shared by the handle slot allocator.
// ----------------------------------------------------------------------------
package hsa_pkg;

	localparam int SLOTS       = 256;
	localparam int HANDLE_BITS = 24;
	localparam int IDX_BITS    = $clog2(SLOTS);
	localparam int PORT_BITS   = 24;
	localparam int CMP_BITS    = (HANDLE_BITS > PORT_BITS) ? HANDLE_BITS : PORT_BITS;

	typedef logic [HANDLE_BITS-1:0] hnd_t;
	typedef logic [IDX_BITS-1:0]    idx_t;
	typedef logic [PORT_BITS-1:0]   phnd_t;
	typedef logic [31:0]            val_t;

	localparam hnd_t HMASK   = '1;
	localparam hnd_t HND_ONE = hnd_t'(1);
	localparam idx_t IDX_LAST = idx_t'(SLOTS - 1);

	typedef enum logic [1:0] {
		ACT_ALLOC  = 2'd0,
		ACT_FREE   = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_NONE   = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NOMATCH = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_RSVD    = 2'd3
	} stat_t;

	typedef enum logic {
		S_IDLE,
		S_PROBE
	} fsm_t;

	// one table entry
	typedef struct packed {
		hnd_t handle;
		val_t entry;
	} slot_t;

	// controller to table
	typedef struct packed {
		idx_t rd_addr;
		logic wr_en;
		logic used_set;
		logic used_clr;
		idx_t wr_addr;
	} tbl_cmd_t;

	// table to controller, registered: valid in the cycle after rd_addr
	typedef struct packed {
		logic  used;
		slot_t data;
	} tbl_rsp_t;

	// successor handle, skipping the reserved zero
	function automatic hnd_t next_handle(hnd_t h);
		return (h == HMASK) ? HND_ONE : hnd_t'(h + HND_ONE);
	endfunction

endpackage

// ----- rtl/hsa_table.sv -----
// ----------------------------------------------------------------------------
// hsa_table
// Slot storage: handle/entry memory with registered read, plus used flags.
// ----------------------------------------------------------------------------
module hsa_table
	import hsa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  tbl_cmd_t cmd,
	input  slot_t    wr_data,
	output tbl_rsp_t rsp
);

	slot_t            mem [SLOTS];
	logic [SLOTS-1:0] used_q;
	slot_t            rd_data_q;
	logic             rd_used_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= wr_data;
		end
		rd_data_q <= mem[cmd.rd_addr];
		rd_used_q <= used_q[cmd.rd_addr];
	end

	// used flags clear at once on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (cmd.used_set) begin
				used_q[cmd.wr_addr] <= 1'b1;
			end else if (cmd.used_clr) begin
				used_q[cmd.wr_addr] <= 1'b0;
			end
		end
	end

	assign rsp.used = rd_used_q;
	assign rsp.data = rd_data_q;

endmodule

// ----- rtl/hsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// hsa_ctrl
// Sequencer: issues slot reads, probes on allocate, commits, holds result.
// ----------------------------------------------------------------------------
module hsa_ctrl
	import hsa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  phnd_t       handle_in,
	input  val_t        entry_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output phnd_t       handle_out,
	output val_t        entry_out,
	output tbl_cmd_t    cmd,
	output slot_t       wr_data,
	input  tbl_rsp_t    rsp
);

	fsm_t  state_q, state_d;
	act_t  act_q;
	phnd_t hin_q;
	val_t  val_q;
	hnd_t  cand_q, cand_d;
	idx_t  cnt_q, cnt_d;
	hnd_t  seed_q, seed_d;
	logic  accept, load, match, out_free;
	stat_t res_status;
	phnd_t res_handle;
	val_t  res_entry;

	logic  out_valid_q;
	stat_t status_q;
	phnd_t handle_q;
	val_t  entry_q;

	assign out_free = !out_valid_q || !out_stall;
	assign match    = rsp.used &&
	                  (CMP_BITS'(rsp.data.handle) == CMP_BITS'(hin_q));
	assign accept   = in_valid && !in_stall;
	assign wr_data  = '{handle: cand_q, entry: val_q};

	always_comb begin
		state_d      = state_q;
		cand_d       = cand_q;
		cnt_d        = cnt_q;
		seed_d       = seed_q;
		in_stall     = (state_q != S_IDLE);
		load         = 1'b0;
		res_status   = STAT_NOMATCH;
		res_handle   = hin_q;
		res_entry    = '0;
		cmd.rd_addr  = idx_t'(hin_q);
		cmd.wr_en    = 1'b0;
		cmd.used_set = 1'b0;
		cmd.used_clr = 1'b0;
		cmd.wr_addr  = idx_t'(hin_q);
		unique case (state_q)
			S_IDLE: begin
				if (act_t'(action) == ACT_ALLOC) begin
					cmd.rd_addr = idx_t'(seed_q);
				end else begin
					cmd.rd_addr = idx_t'(handle_in);
				end
				if (in_valid) begin
					state_d = S_PROBE;
					cand_d  = seed_q;
					cnt_d   = '0;
				end
			end
			S_PROBE: begin
				if (act_q == ACT_ALLOC) begin
					cmd.rd_addr = idx_t'(cand_q);
					cmd.wr_addr = idx_t'(cand_q);
					if (!rsp.used) begin
						res_status = STAT_OK;
						res_handle = phnd_t'(cand_q);
						if (out_free) begin
							load         = 1'b1;
							cmd.wr_en    = 1'b1;
							cmd.used_set = 1'b1;
							seed_d       = next_handle(cand_q);
							state_d      = S_IDLE;
						end
					end else if (cnt_q == IDX_LAST) begin
						res_status = STAT_FULL;
						res_handle = '0;
						if (out_free) begin
							load    = 1'b1;
							state_d = S_IDLE;
						end
					end else begin
						// slot taken: try the next candidate
						cand_d      = next_handle(cand_q);
						cnt_d       = idx_t'(cnt_q + idx_t'(1));
						cmd.rd_addr = idx_t'(next_handle(cand_q));
					end
				end else begin
					if ((act_q == ACT_FREE || act_q == ACT_LOOKUP) && match) begin
						res_status = STAT_OK;
						res_entry  = rsp.data.entry;
					end
					if (out_free) begin
						load         = 1'b1;
						cmd.used_clr = (act_q == ACT_FREE) && match;
						state_d      = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seed_q      <= HND_ONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			seed_q  <= seed_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cand_q <= cand_d;
		cnt_q  <= cnt_d;
		if (accept) begin
			act_q <= act_t'(action);
			hin_q <= handle_in;
			val_q <= entry_value;
		end
		if (load) begin
			status_q <= res_status;
			handle_q <= res_handle;
			entry_q  <= res_entry;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign handle_out = handle_q;
	assign entry_out  = entry_q;

endmodule

// ----- rtl/handle_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// handle_slot_allocator
// Free, lookup and unused codes read one slot and return a result; allocate
// probes slots from the seed (1 .. SLOTS probed) and returns full if none is free.
// One item in flight: a new item is taken only once the last result is registered.
// Reset: used flags clear at once, seed goes to 1; no clearing pass needed.
// ----------------------------------------------------------------------------
module handle_slot_allocator
	import hsa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [23:0] handle_in,
	input  logic [31:0] entry_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [23:0] handle_out,
	output logic [31:0] entry_out
);

	// Table: handle/entry pairs in one synchronous memory, used flags in
	// flops so reset empties the table instantly. Every read is registered;
	// writes only happen on the commit cycle, after which the controller
	// goes idle, so a following read always sees the new data.
	tbl_cmd_t cmd;
	tbl_rsp_t rsp;
	slot_t    wr_data;

	hsa_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.wr_data (wr_data),
		.rsp     (rsp)
	);

	// Controller: one item in flight. Allocate walks candidates from the
	// seed, one slot read per cycle, and stops at the first free slot or
	// after SLOTS tries. The result register lets a new item be taken
	// while the last result still waits at the output.
	hsa_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.handle_in   (handle_in),
		.entry_value (entry_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.handle_out  (handle_out),
		.entry_out   (entry_out),
		.cmd         (cmd),
		.wr_data     (wr_data),
		.rsp         (rsp)
	);

endmodule

// ----- rtl/hsa_checker.sv -----
// ----------------------------------------------------------------------------
// hsa_checker
// Port-level checks for the handle slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module hsa_checker
	import hsa_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  action,
	input logic [23:0] handle_in,
	input logic [31:0] entry_value,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [23:0] handle_out,
	input logic [31:0] entry_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(handle_out) && $stable(entry_out))
		else $error("stalled result changed");

	// one item at a time: busy right after accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	a_no_rsvd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != STAT_RSVD)
		else $error("reserved status code");

	// failures carry no entry; full carries no handle
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> entry_out == '0 &&
		(status != STAT_FULL || handle_out == '0))
		else $error("failure result carries data");

endmodule

bind handle_slot_allocator hsa_checker u_hsa_checker (.*);
